// ----- hw/rtl/pisa_pkg.sv -----
// Shared constants for the pairwise inverse-square acceleration pipeline.
package pisa_pkg;

	localparam int MASS_W    = 32;
	localparam int ACC_FRAC  = 24;
	localparam int OUT_W     = 48;
	localparam int MUL_DIGIT = 8;

endpackage

// ----- hw/rtl/pairwise_inverse_square_accel_unit.sv -----
// Top level of the pairwise inverse-square acceleration pipeline.
// Throughput: one beat per cycle while the skid entry of the output buffer is empty; the 3*CW+5
// stage square root and the 48 stage divider set the depth, and a two-entry output buffer lets
// input beats flow while a result waits.
// Reset clears every valid bit, including those of the output buffer; data registers are not reset.
module pairwise_inverse_square_accel_unit import pisa_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int COORD_FRAC_BITS = 16,
	localparam int IN_DW = ((4 * COORD_WIDTH + MASS_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// target_x, target_y, source_x, source_y, source_mass, zero fill
	input  logic [IN_DW-1:0]   s_axis_tdata,
	// is_self
	input  logic               s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// accel_x, accel_y
	output logic [2*OUT_W-1:0] m_axis_tdata,
	// saturated
	output logic               m_axis_tuser
);

	localparam int CW      = COORD_WIDTH;
	localparam int MW      = CW + 1;
	localparam int SW      = 2 * MW + 1;
	localparam int S2W     = 2 * SW;
	localparam int S3W     = 3 * SW;
	localparam int RWP     = S3W + (S3W % 2);
	localparam int RTW     = RWP / 2;
	localparam int PRW     = MW + MASS_W;
	localparam int SHF     = COORD_FRAC_BITS + ACC_FRAC;
	localparam int NW      = PRW + SHF;
	localparam int CMPW    = NW + RTW;
	localparam int O_MX    = 4;
	localparam int O_MY    = O_MX + MW;
	localparam int O_MASS  = O_MY + MW;
	localparam int SIDE1_W = O_MASS + MASS_W;

	logic                    en;
	logic                    vld_s1;
	logic signed [CW:0]      dx_s1, dy_s1;
	logic [MASS_W-1:0]       mass_s1;
	logic                    self_s1;
	logic                    vld_s2;
	logic [SIDE1_W-1:0]      side_s2;
	logic [MW-1:0]           mx_c, my_c;

	logic                    sq_vld;
	logic [2*MW-1:0]         sqx_p, sqy_p;
	logic [SIDE1_W-1:0]      sq_side;
	logic                    vld_s3;
	logic [SW-1:0]           s_s3;
	logic [SIDE1_W-1:0]      side_s3;

	logic                    p2_vld;
	logic [S2W-1:0]          p2;
	logic [SW+SIDE1_W-1:0]   p2_side;
	logic                    p3_vld;
	logic [S3W-1:0]          p3;
	logic [SIDE1_W-1:0]      p3_side;

	logic                    rt_vld;
	logic [RTW-1:0]          root;
	logic [SIDE1_W-1:0]      rt_side;

	logic                    nm_vld;
	logic [PRW-1:0]          nmx_p, nmy_p;
	logic [RTW+SIDE1_W-1:0]  nm_side;
	logic [NW-1:0]           nfx_c, nfy_c;
	logic                    vld_s4;
	logic [NW-1:0]           nfx_s4, nfy_s4;
	logic [RTW-1:0]          root_s4;
	logic                    ovfx_s4, ovfy_s4;
	logic [SIDE1_W-1:0]      side_s4;

	logic                    dv_vld;
	logic [OUT_W-1:0]        qx, qy;
	logic [SIDE1_W+1:0]      dv_side;

	logic [2*OUT_W-1:0]      fmt_data;
	logic                    fmt_sat;
	logic                    out_vld_q, skid_vld_q;
	logic [2*OUT_W-1:0]      out_data_q, skid_data_q;
	logic                    out_sat_q, skid_sat_q;

	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= sq_vld;
			vld_s4 <= nm_vld;
		end
	end

	assign mx_c = dx_s1[CW] ? MW'(-dx_s1) : MW'(dx_s1);
	assign my_c = dy_s1[CW] ? MW'(-dy_s1) : MW'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= $signed({s_axis_tdata[3*CW-1], s_axis_tdata[2*CW +: CW]})
			         - $signed({s_axis_tdata[CW-1], s_axis_tdata[0 +: CW]});
			dy_s1   <= $signed({s_axis_tdata[4*CW-1], s_axis_tdata[3*CW +: CW]})
			         - $signed({s_axis_tdata[2*CW-1], s_axis_tdata[CW +: CW]});
			mass_s1 <= s_axis_tdata[4*CW +: MASS_W];
			self_s1 <= s_axis_tuser;
			side_s2 <= {mass_s1, my_c, mx_c, dy_s1[CW], dx_s1[CW],
			            (dx_s1 == '0) && (dy_s1 == '0), self_s1};
			s_s3    <= SW'(sqx_p) + SW'(sqy_p);
			side_s3 <= sq_side;
			nfx_s4  <= nfx_c;
			nfy_s4  <= nfy_c;
			root_s4 <= nm_side[SIDE1_W +: RTW];
			ovfx_s4 <= CMPW'(nfx_c >> OUT_W) >= CMPW'(nm_side[SIDE1_W +: RTW]);
			ovfy_s4 <= CMPW'(nfy_c >> OUT_W) >= CMPW'(nm_side[SIDE1_W +: RTW]);
			side_s4 <= nm_side[SIDE1_W-1:0];
		end
	end

	pisa_mul #(.WA(MW), .WB(MW), .SIDE_W(SIDE1_W)) u_sqx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s2), .a_i(side_s2[O_MX +: MW]), .b_i(side_s2[O_MX +: MW]), .side_i(side_s2),
		.vld_o(sq_vld), .p_o(sqx_p), .side_o(sq_side)
	);

	pisa_mul #(.WA(MW), .WB(MW), .SIDE_W(1)) u_sqy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s2), .a_i(side_s2[O_MY +: MW]), .b_i(side_s2[O_MY +: MW]), .side_i(1'b0),
		.vld_o(), .p_o(sqy_p), .side_o()
	);

	pisa_mul #(.WA(SW), .WB(SW), .SIDE_W(SW+SIDE1_W)) u_s2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s3), .a_i(s_s3), .b_i(s_s3), .side_i({s_s3, side_s3}),
		.vld_o(p2_vld), .p_o(p2), .side_o(p2_side)
	);

	pisa_mul #(.WA(S2W), .WB(SW), .SIDE_W(SIDE1_W)) u_s3 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(p2_vld), .a_i(p2), .b_i(p2_side[SIDE1_W +: SW]),
		.side_i(p2_side[SIDE1_W-1:0]),
		.vld_o(p3_vld), .p_o(p3), .side_o(p3_side)
	);

	pisa_sqrt #(.RW(RWP), .SIDE_W(SIDE1_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(p3_vld), .rad_i(RWP'(p3)), .side_i(p3_side),
		.vld_o(rt_vld), .root_o(root), .side_o(rt_side)
	);

	pisa_mul #(.WA(MW), .WB(MASS_W), .SIDE_W(RTW+SIDE1_W)) u_nmx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(rt_vld), .a_i(rt_side[O_MX +: MW]), .b_i(rt_side[O_MASS +: MASS_W]),
		.side_i({root, rt_side}),
		.vld_o(nm_vld), .p_o(nmx_p), .side_o(nm_side)
	);

	pisa_mul #(.WA(MW), .WB(MASS_W), .SIDE_W(1)) u_nmy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(rt_vld), .a_i(rt_side[O_MY +: MW]), .b_i(rt_side[O_MASS +: MASS_W]),
		.side_i(1'b0),
		.vld_o(), .p_o(nmy_p), .side_o()
	);

	assign nfx_c = {nmx_p, {SHF{1'b0}}};
	assign nfy_c = {nmy_p, {SHF{1'b0}}};

	pisa_div #(.NW(NW), .DNW(RTW), .QB(OUT_W), .SIDE_W(SIDE1_W+2)) u_divx (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s4), .n_i(nfx_s4), .d_i(root_s4), .side_i({ovfy_s4, ovfx_s4, side_s4}),
		.vld_o(dv_vld), .q_o(qx), .side_o(dv_side)
	);

	pisa_div #(.NW(NW), .DNW(RTW), .QB(OUT_W), .SIDE_W(1)) u_divy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(vld_s4), .n_i(nfy_s4), .d_i(root_s4), .side_i(1'b0),
		.vld_o(), .q_o(qy), .side_o()
	);

	always_comb begin
		logic [OUT_W-1:0] limx, limy, magx, magy, ax, ay;
		logic             clipx, clipy;

		limx  = dv_side[2] ? (OUT_W)'(1) << (OUT_W-1) : ((OUT_W)'(1) << (OUT_W-1)) - 1'b1;
		limy  = dv_side[3] ? (OUT_W)'(1) << (OUT_W-1) : ((OUT_W)'(1) << (OUT_W-1)) - 1'b1;
		clipx = dv_side[SIDE1_W] || (qx > limx);
		clipy = dv_side[SIDE1_W+1] || (qy > limy);
		magx  = clipx ? limx : qx;
		magy  = clipy ? limy : qy;
		ax    = dv_side[2] ? -magx : magx;
		ay    = dv_side[3] ? -magy : magy;
		if (dv_side[0]) begin
			fmt_data = '0;
			fmt_sat  = 1'b0;
		end else if (dv_side[1]) begin
			fmt_data = '0;
			fmt_sat  = 1'b1;
		end else begin
			fmt_data = {ay, ax};
			fmt_sat  = clipx || clipy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_axis_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (dv_vld) begin
			if (out_vld_q && !m_axis_tready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
				out_sat_q  <= skid_sat_q;
			end
		end else if (dv_vld) begin
			if (out_vld_q && !m_axis_tready) begin
				skid_data_q <= fmt_data;
				skid_sat_q  <= fmt_sat;
			end else begin
				out_data_q <= fmt_data;
				out_sat_q  <= fmt_sat;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule

// ----- hw/rtl/pisa_mul.sv -----
// Pipelined unsigned multiplier that consumes one digit of the second operand per stage.
module pisa_mul import pisa_pkg::*; #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [WA-1:0]     a_i,
	input  logic [WB-1:0]     b_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [WA+WB-1:0]  p_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int DGT = MUL_DIGIT;
	localparam int NS  = (WB + DGT - 1) / DGT;
	localparam int BP  = NS * DGT;
	localparam int PW  = WA + WB;

	logic              vld_s  [NS+1];
	logic [WA-1:0]     a_s    [NS+1];
	logic [BP-1:0]     b_s    [NS+1];
	logic [PW-1:0]     acc_s  [NS+1];
	logic [SIDE_W-1:0] side_s [NS+1];

	assign vld_s[0]  = vld_i;
	assign a_s[0]    = a_i;
	assign b_s[0]    = BP'(b_i);
	assign acc_s[0]  = '0;
	assign side_s[0] = side_i;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [WA+DGT-1:0] pp;

		assign pp = a_s[k] * b_s[k][k*DGT +: DGT];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k+1]    <= a_s[k];
				b_s[k+1]    <= b_s[k];
				side_s[k+1] <= side_s[k];
				acc_s[k+1]  <= acc_s[k] + (PW'(pp) << (k*DGT));
			end
		end
	end

	assign vld_o  = vld_s[NS];
	assign p_o    = acc_s[NS];
	assign side_o = side_s[NS];

endmodule

// ----- hw/rtl/pisa_sqrt.sv -----
// Pipelined integer square root, one root bit resolved per stage.
module pisa_sqrt #(
	parameter int RW = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [RW-1:0]     rad_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [RW/2-1:0]   root_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int QW   = RW / 2;
	localparam int REMW = QW + 2;

	logic              vld_s  [QW+1];
	logic [RW-1:0]     rad_s  [QW+1];
	logic [QW-1:0]     root_s [QW+1];
	logic [REMW-1:0]   rem_s  [QW+1];
	logic [SIDE_W-1:0] side_s [QW+1];

	assign vld_s[0]  = vld_i;
	assign rad_s[0]  = rad_i;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = side_i;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [REMW+1:0] rem2;
		logic [REMW+1:0] trial;
		logic [REMW+1:0] diff;
		logic            ge;

		assign rem2  = {rem_s[k], rad_s[k][RW-1 -: 2]};
		assign trial = (REMW+2)'({root_s[k], 2'b01});
		assign diff  = rem2 - trial;
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k] << 2;
				root_s[k+1] <= {root_s[k][QW-2:0], ge};
				rem_s[k+1]  <= ge ? diff[REMW-1:0] : rem2[REMW-1:0];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_o  = vld_s[QW];
	assign root_o = root_s[QW];
	assign side_o = side_s[QW];

endmodule

// ----- hw/rtl/pisa_div.sv -----
// Pipelined restoring divider producing a fixed number of quotient bits, one per stage.
module pisa_div #(
	parameter int NW = 64,
	parameter int DNW = 32,
	parameter int QB = 48,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [NW-1:0]     n_i,
	input  logic [DNW-1:0]    d_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [QB-1:0]     q_o,
	output logic [SIDE_W-1:0] side_o
);

	localparam int RMW = DNW + 1;

	logic              vld_s  [QB+1];
	logic [RMW-1:0]    rem_s  [QB+1];
	logic [QB-1:0]     nlo_s  [QB+1];
	logic [QB-1:0]     q_s    [QB+1];
	logic [DNW-1:0]    d_s    [QB+1];
	logic [SIDE_W-1:0] side_s [QB+1];

	// The quotient bits above the kept ones are zero whenever the result is used.
	assign vld_s[0]  = vld_i;
	assign rem_s[0]  = RMW'(n_i >> QB);
	assign nlo_s[0]  = n_i[QB-1:0];
	assign q_s[0]    = '0;
	assign d_s[0]    = d_i;
	assign side_s[0] = side_i;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [RMW:0] rem2;
		logic [RMW:0] diff;
		logic         ge;

		assign rem2 = {rem_s[k], nlo_s[k][QB-1]};
		assign diff = rem2 - (RMW+1)'(d_s[k]);
		assign ge   = !diff[RMW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[RMW-1:0] : rem2[RMW-1:0];
				nlo_s[k+1]  <= nlo_s[k] << 1;
				q_s[k+1]    <= {q_s[k][QB-2:0], ge};
				d_s[k+1]    <= d_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_o  = vld_s[QB];
	assign q_o    = q_s[QB];
	assign side_o = side_s[QB];

endmodule
